### src/heightfield_bilinear_sampler_top_macros.svh
// assertion macros, sampled on clk, reset is rst_n
`ifndef HEIGHTFIELD_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define HBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HBS_ASSERT(lbl, prop, msg)
`define HBS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### src/hbs_pkg.sv
package hbs_pkg;

  localparam int GRID_POINTS = 64;
  localparam int IDX_W       = $clog2(GRID_POINTS);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int CELLS       = GRID_POINTS * GRID_POINTS;
  localparam int HEIGHT_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int COORD_W     = 18;
  localparam int WEIGHT_W    = FRAC_W + 1;
  localparam int SCALED_W    = FRAC_W + IDX_W;
  localparam int LINE_W      = HEIGHT_W + FRAC_W;
  localparam int ACC_W       = HEIGHT_W + 2 * FRAC_W;
  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 16;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_M4,
    ST_M5,
    ST_Z0,
    ST_Z1,
    ST_Z2,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    MS_RD,
    MS_H0,
    MS_H1
  } mul_src_t;

  typedef enum logic [1:0] {
    W_X0,
    W_X1,
    W_Z0,
    W_Z1
  } mul_w_t;

  typedef enum logic [2:0] {
    D_NONE,
    D_H0_LD,
    D_H0_ADD,
    D_H1_LD,
    D_H1_ADD,
    D_ACC_LD,
    D_ACC_ADD
  } dst_t;

  typedef struct packed {
    logic     capture;
    logic     mem_we;
    logic [1:0] corner;
    logic     mul_en;
    mul_src_t mul_src;
    mul_w_t   mul_w;
    dst_t     dst;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

### src/hbs_ctrl.sv
`include "heightfield_bilinear_sampler_top_macros.svh"

module hbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tuser,
  output logic          in_tready,
  input  hbs_pkg::sts_t sts,
  output hbs_pkg::cmd_t cmd
);

  hbs_pkg::state_t state_r;
  hbs_pkg::state_t state_nxt;
  logic            accept;

  assign in_tready = (state_r == hbs_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbs_pkg::ST_IDLE: begin
        if (accept && in_tuser == hbs_pkg::CMD_SAMPLE) begin
          state_nxt = hbs_pkg::ST_RD0;
        end
      end
      hbs_pkg::ST_RD0: state_nxt = hbs_pkg::ST_RD1;
      hbs_pkg::ST_RD1: state_nxt = hbs_pkg::ST_RD2;
      hbs_pkg::ST_RD2: state_nxt = hbs_pkg::ST_RD3;
      hbs_pkg::ST_RD3: state_nxt = hbs_pkg::ST_M4;
      hbs_pkg::ST_M4:  state_nxt = hbs_pkg::ST_M5;
      hbs_pkg::ST_M5:  state_nxt = hbs_pkg::ST_Z0;
      hbs_pkg::ST_Z0:  state_nxt = hbs_pkg::ST_Z1;
      hbs_pkg::ST_Z1:  state_nxt = hbs_pkg::ST_Z2;
      hbs_pkg::ST_Z2:  state_nxt = hbs_pkg::ST_FIN;
      hbs_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          state_nxt = hbs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_src  = hbs_pkg::MS_RD;
    cmd.mul_w    = hbs_pkg::W_X0;
    cmd.dst      = hbs_pkg::D_NONE;
    unique case (state_r)
      hbs_pkg::ST_IDLE: begin
        cmd.capture = accept && (in_tuser == hbs_pkg::CMD_SAMPLE);
        cmd.mem_we  = accept && (in_tuser == hbs_pkg::CMD_LOAD);
      end
      hbs_pkg::ST_RD0: begin
        cmd.corner = 2'd0;
      end
      hbs_pkg::ST_RD1: begin
        cmd.corner = 2'd1;
        cmd.mul_en = 1'b1;
        cmd.mul_w  = hbs_pkg::W_X0;
      end
      hbs_pkg::ST_RD2: begin
        cmd.corner = 2'd2;
        cmd.mul_en = 1'b1;
        cmd.mul_w  = hbs_pkg::W_X1;
        cmd.dst    = hbs_pkg::D_H0_LD;
      end
      hbs_pkg::ST_RD3: begin
        cmd.corner = 2'd3;
        cmd.mul_en = 1'b1;
        cmd.mul_w  = hbs_pkg::W_X0;
        cmd.dst    = hbs_pkg::D_H0_ADD;
      end
      hbs_pkg::ST_M4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_w  = hbs_pkg::W_X1;
        cmd.dst    = hbs_pkg::D_H1_LD;
      end
      hbs_pkg::ST_M5: begin
        cmd.dst = hbs_pkg::D_H1_ADD;
      end
      hbs_pkg::ST_Z0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = hbs_pkg::MS_H0;
        cmd.mul_w   = hbs_pkg::W_Z0;
      end
      hbs_pkg::ST_Z1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = hbs_pkg::MS_H1;
        cmd.mul_w   = hbs_pkg::W_Z1;
        cmd.dst     = hbs_pkg::D_ACC_LD;
      end
      hbs_pkg::ST_Z2: begin
        cmd.dst = hbs_pkg::D_ACC_ADD;
      end
      hbs_pkg::ST_FIN: begin
        cmd.out_load = !sts.out_busy;
      end
      default: begin
        cmd.corner = 2'd0;
      end
    endcase
  end

  `HBS_ASSERT(a_sample_starts,
    (accept && in_tuser == hbs_pkg::CMD_SAMPLE) |=> (state_r == hbs_pkg::ST_RD0),
    "sample beat did not start a read sequence")
  `HBS_ASSERT(a_load_stays_idle,
    (accept && in_tuser == hbs_pkg::CMD_LOAD) |=> (state_r == hbs_pkg::ST_IDLE),
    "load beat left the idle state")
  `HBS_ASSERT(a_no_overwrite,
    cmd.out_load |-> !sts.out_busy,
    "result loaded while previous result still pending")
  `HBS_ASSERT_RST(a_reset_idle,
    !$past(rst_n) |-> (state_r == hbs_pkg::ST_IDLE),
    "controller not idle after reset")

endmodule

### src/hbs_dp.sv
module hbs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hbs_pkg::cmd_t                    cmd,
  output hbs_pkg::sts_t                    sts,
  input  logic [hbs_pkg::IDX_W-1:0]        load_col,
  input  logic [hbs_pkg::IDX_W-1:0]        load_row,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0] load_height,
  input  logic signed [hbs_pkg::COORD_W-1:0]  sample_x,
  input  logic signed [hbs_pkg::COORD_W-1:0]  sample_z,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic signed [hbs_pkg::HEIGHT_W-1:0] height_out
);

  localparam int MUL_A_W = hbs_pkg::LINE_W;
  localparam int MUL_B_W = hbs_pkg::WEIGHT_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  logic [hbs_pkg::HEIGHT_W-1:0] mem [hbs_pkg::CELLS];
  logic [hbs_pkg::HEIGHT_W-1:0] rdata_r;
  logic [hbs_pkg::ADDR_W-1:0]   raddr;

  logic [hbs_pkg::IDX_W-1:0]  cx_r, cz_r;
  logic [hbs_pkg::FRAC_W-1:0] fx_r, fz_r;
  logic [hbs_pkg::IDX_W-1:0]  cx_nxt, cz_nxt;
  logic [hbs_pkg::FRAC_W-1:0] fx_nxt, fz_nxt;

  logic signed [MUL_A_W-1:0]           mul_a;
  logic [hbs_pkg::WEIGHT_W-1:0]        mul_w;
  logic signed [PROD_W-1:0]            prod;
  logic signed [hbs_pkg::ACC_W-1:0]    prod_r;
  logic signed [hbs_pkg::LINE_W-1:0]   h0_r, h1_r;
  logic signed [hbs_pkg::ACC_W-1:0]    acc_r;
  logic                                out_valid_r;
  logic signed [hbs_pkg::HEIGHT_W-1:0] out_data_r;

  function automatic logic [hbs_pkg::SCALED_W-1:0] scale_coord(
    input logic signed [hbs_pkg::COORD_W-1:0] c
  );
    logic [hbs_pkg::FRAC_W-1:0] cl;
    begin
      if (c[hbs_pkg::COORD_W-1]) begin
        cl = '0;
      end else if (|c[hbs_pkg::COORD_W-2:hbs_pkg::FRAC_W]) begin
        cl = '1;
      end else begin
        cl = c[hbs_pkg::FRAC_W-1:0];
      end
      scale_coord = hbs_pkg::SCALED_W'(cl) * hbs_pkg::SCALED_W'(hbs_pkg::GRID_POINTS - 1);
    end
  endfunction

  // clamp and scale, cell index in the high bits
  always_comb begin
    logic [hbs_pkg::SCALED_W-1:0] gx, gz;
    gx     = scale_coord(sample_x);
    gz     = scale_coord(sample_z);
    cx_nxt = gx[hbs_pkg::SCALED_W-1:hbs_pkg::FRAC_W];
    fx_nxt = gx[hbs_pkg::FRAC_W-1:0];
    cz_nxt = gz[hbs_pkg::SCALED_W-1:hbs_pkg::FRAC_W];
    fz_nxt = gz[hbs_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx_r <= cx_nxt;
      fx_r <= fx_nxt;
      cz_r <= cz_nxt;
      fz_r <= fz_nxt;
    end
  end

  // corner address, row major
  always_comb begin
    case (cmd.corner)
      2'd0:    raddr = {cz_r, cx_r};
      2'd1:    raddr = {cz_r, cx_r + 1'b1};
      2'd2:    raddr = {cz_r + 1'b1, cx_r};
      default: raddr = {cz_r + 1'b1, cx_r + 1'b1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[{load_row, load_col}] <= load_height;
    end
    rdata_r <= mem[raddr];
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_src)
      hbs_pkg::MS_H0: mul_a = h0_r;
      hbs_pkg::MS_H1: mul_a = h1_r;
      default: mul_a = {{(MUL_A_W - hbs_pkg::HEIGHT_W){rdata_r[hbs_pkg::HEIGHT_W-1]}}, rdata_r};
    endcase
    case (cmd.mul_w)
      hbs_pkg::W_X0: mul_w = (hbs_pkg::WEIGHT_W'(1) << hbs_pkg::FRAC_W) - {1'b0, fx_r};
      hbs_pkg::W_X1: mul_w = {1'b0, fx_r};
      hbs_pkg::W_Z0: mul_w = (hbs_pkg::WEIGHT_W'(1) << hbs_pkg::FRAC_W) - {1'b0, fz_r};
      default:       mul_w = {1'b0, fz_r};
    endcase
    prod = PROD_W'(mul_a) * PROD_W'(signed'({1'b0, mul_w}));
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod[hbs_pkg::ACC_W-1:0];
    end
    case (cmd.dst)
      hbs_pkg::D_H0_LD:   h0_r  <= prod_r[hbs_pkg::LINE_W-1:0];
      hbs_pkg::D_H0_ADD:  h0_r  <= h0_r + prod_r[hbs_pkg::LINE_W-1:0];
      hbs_pkg::D_H1_LD:   h1_r  <= prod_r[hbs_pkg::LINE_W-1:0];
      hbs_pkg::D_H1_ADD:  h1_r  <= h1_r + prod_r[hbs_pkg::LINE_W-1:0];
      hbs_pkg::D_ACC_LD:  acc_r <= prod_r;
      hbs_pkg::D_ACC_ADD: acc_r <= acc_r + prod_r;
      default: ;
    endcase
  end

  // result register, floor by dropping the fraction bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= acc_r[hbs_pkg::ACC_W-1:2*hbs_pkg::FRAC_W];
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign height_out   = out_data_r;

endmodule

### src/heightfield_bilinear_sampler_top.sv
// channel | dir | tdata (low bit up)                                   | tuser
// in_     | in  | load_col[5:0] load_row[11:6] load_height[27:12]      | command
//         |     | sample_x[45:28] sample_z[63:46]                      |
// out_    | out | height_out[15:0]                                     | -
//
// a load beat is written to the grid in its accept cycle; the next beat may follow at once
// a sample beat holds the block from accept until it returns to idle, through four
// corner reads through the single grid read port and six passes of the shared multiplier
// the result waits in an output register; loads are taken while it waits
// a stalled result register delays only the return to idle of the following sample
// reset is synchronous, active low; grid contents are not cleared
module heightfield_bilinear_sampler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // load_col, load_row, load_height, sample_x, sample_z
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // height_out
);

  hbs_pkg::cmd_t cmd;
  hbs_pkg::sts_t sts;
  logic signed [hbs_pkg::HEIGHT_W-1:0] height_out;

  hbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbs_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .load_col    (in_tdata[5:0]),
    .load_row    (in_tdata[11:6]),
    .load_height (signed'(in_tdata[27:12])),
    .sample_x    (signed'(in_tdata[45:28])),
    .sample_z    (signed'(in_tdata[63:46])),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .height_out  (height_out)
  );

  assign out_tdata = height_out;

endmodule
